// ===== rtl/direct_mapped_slot_stats_table_core_defines.svh =====
// Assertion macros shared by the slot statistics table modules.
`ifndef DIRECT_MAPPED_SLOT_STATS_TABLE_CORE_DEFINES_SVH
`define DIRECT_MAPPED_SLOT_STATS_TABLE_CORE_DEFINES_SVH

// Clocked check, off while reset is high.
`define DMST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DMST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/dmst_pkg.sv =====
// Types and constants of the slot statistics table.
package dmst_pkg;

   localparam int TAG_W  = 64;
   localparam int TIME_W = 64;
   localparam int CNT_W  = 32;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_SHRED = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // Data shred origins
   localparam logic [1:0] SRC_REPAIR    = 2'd0;
   localparam logic [1:0] SRC_TURBINE   = 2'd1;
   localparam logic [1:0] SRC_RECOVERED = 2'd2;

   // Operation of a queued item
   localparam logic OP_CLAIM = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Counter to bump after a claim
   localparam logic [2:0] BUMP_NONE      = 3'd0;
   localparam logic [2:0] BUMP_TURBINE   = 3'd1;
   localparam logic [2:0] BUMP_REPAIR    = 3'd2;
   localparam logic [2:0] BUMP_RECOVERED = 3'd3;
   localparam logic [2:0] BUMP_CODING    = 3'd4;

   typedef struct packed {
      logic              op;
      logic [2:0]        bump;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] ts;
   } dmst_item_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] first_time;
      logic [CNT_W-1:0]  turbine;
      logic [CNT_W-1:0]  repair;
      logic [CNT_W-1:0]  recovered;
      logic [CNT_W-1:0]  coding;
   } dmst_entry_type;

   localparam dmst_entry_type ENTRY_RESET = '{
      tag:        {TAG_W{1'b1}},
      first_time: '0,
      turbine:    '0,
      repair:     '0,
      recovered:  '0,
      coding:     '0
   };

   // Translate a request into a queued operation.
   function automatic dmst_item_type classify(input logic [1:0] kind,
                                              input logic [TAG_W-1:0] slot,
                                              input logic is_data,
                                              input logic [1:0] source,
                                              input logic [TIME_W-1:0] ts);
      dmst_item_type item;
      item.tag  = slot;
      item.ts   = ts;
      item.op   = (kind == KIND_QUERY) ? OP_QUERY : OP_CLAIM;
      item.bump = BUMP_NONE;
      if (kind == KIND_SHRED) begin
         if (!is_data) begin
            item.bump = BUMP_CODING;
         end else begin
            case (source)
               SRC_REPAIR:    item.bump = BUMP_REPAIR;
               SRC_TURBINE:   item.bump = BUMP_TURBINE;
               SRC_RECOVERED: item.bump = BUMP_RECOVERED;
               default:       item.bump = BUMP_NONE;
            endcase
         end
      end
      return item;
   endfunction

endpackage

// ===== rtl/dmst_front.sv =====
// Request front end: accepts beats, drops unused kinds, computes the entry index.
`include "direct_mapped_slot_stats_table_core_defines.svh"
module dmst_front
   import dmst_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned IDX_W         = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [TAG_W-1:0]    req_slot_number,
   input  logic                req_is_data,
   input  logic [1:0]          req_source,
   input  logic [TIME_W-1:0]   req_timestamp,
   input  logic                clear_busy,
   output logic                push_valid,
   input  logic                push_ready,
   output dmst_item_type       push_item,
   output logic [IDX_W-1:0]    push_idx
);

   localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

   logic          kind_used;
   dmst_item_type req_item;

   assign kind_used = (req_kind == KIND_START) || (req_kind == KIND_SHRED) ||
                      (req_kind == KIND_QUERY);
   assign req_item  = classify(req_kind, req_slot_number, req_is_data, req_source,
                               req_timestamp);

   generate
      if (IS_POW2) begin : g_mask
         // Index is the low bits of the slot number.
         assign req_ready  = !clear_busy && push_ready;
         assign push_valid = req_valid && !clear_busy && kind_used;
         assign push_item  = req_item;
         assign push_idx   = (TABLE_ENTRIES == 1) ? '0 : req_slot_number[IDX_W-1:0];
      end else begin : g_rem
         localparam logic [2:0] F_IDLE = 3'd0;
         localparam logic [2:0] F_FOLD = 3'd1;
         localparam logic [2:0] F_MUL  = 3'd2;
         localparam logic [2:0] F_SUB  = 3'd3;
         localparam logic [2:0] F_PUSH = 3'd4;
         // Residues of 2^16, 2^32 and 2^48, and floor(2^34 / TABLE_ENTRIES).
         localparam logic [31:0] RES16 = 32'((64'd1 << 16) % 64'(TABLE_ENTRIES));
         localparam logic [31:0] RES32 = 32'((64'd1 << 32) % 64'(TABLE_ENTRIES));
         localparam logic [31:0] RES48 = 32'((64'd1 << 48) % 64'(TABLE_ENTRIES));
         localparam logic [32:0] RECIP = 33'((64'd1 << 34) / 64'(TABLE_ENTRIES));
         localparam logic [33:0] MOD34 = 34'(TABLE_ENTRIES);

         logic [2:0]       state_ff, state_in;
         logic [TAG_W-1:0] slot_ff;
         dmst_item_type    item_ff;
         logic [33:0]      fold_ff, diff_ff;
         logic [32:0]      quot_ff;
         logic [31:0]      part1, part2, part3;
         logic [33:0]      fold_sum, quot_mul, idx_full;
         logic [66:0]      recip_prod;
         logic             accept;

         assign accept = req_valid && req_ready;

         // Fold the four 16-bit slot digits by their residues; the sum stays below 2^34.
         assign part1    = {16'd0, slot_ff[31:16]} * RES16;
         assign part2    = {16'd0, slot_ff[47:32]} * RES32;
         assign part3    = {16'd0, slot_ff[63:48]} * RES48;
         assign fold_sum = {18'd0, slot_ff[15:0]} + {2'b00, part1} + {2'b00, part2} +
                           {2'b00, part3};

         // Quotient estimate is low by at most one, so one compare and subtract finishes.
         assign recip_prod = {33'd0, fold_ff} * {34'd0, RECIP};
         assign quot_mul   = {1'b0, quot_ff} * MOD34;
         assign idx_full   = (diff_ff >= MOD34) ? (diff_ff - MOD34) : diff_ff;

         always_comb begin
            state_in = state_ff;
            unique case (state_ff)
               F_IDLE: begin
                  if (accept && kind_used) begin
                     state_in = F_FOLD;
                  end
               end
               F_FOLD: state_in = F_MUL;
               F_MUL:  state_in = F_SUB;
               F_SUB:  state_in = F_PUSH;
               F_PUSH: begin
                  if (push_ready) begin
                     state_in = F_IDLE;
                  end
               end
               default: state_in = F_IDLE;
            endcase
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               state_ff <= F_IDLE;
            end else begin
               state_ff <= state_in;
            end
            if (accept && kind_used) begin
               slot_ff <= req_slot_number;
               item_ff <= req_item;
            end
            if (state_ff == F_FOLD) begin
               fold_ff <= fold_sum;
            end
            if (state_ff == F_MUL) begin
               quot_ff <= recip_prod[66:34];
            end
            if (state_ff == F_SUB) begin
               diff_ff <= fold_ff - quot_mul;
            end
         end

         assign req_ready  = (state_ff == F_IDLE) && !clear_busy;
         assign push_valid = (state_ff == F_PUSH);
         assign push_item  = item_ff;
         assign push_idx   = idx_full[IDX_W-1:0];

         `DMST_ASSERT(a_rem_in_range, (state_ff != F_PUSH) || (idx_full < MOD34),
            "remainder left the table range")
         `DMST_ASSERT(a_push_holds, (push_valid && !push_ready) |=> (push_valid && $stable(push_idx) && $stable(push_item)),
            "queued beat changed while waiting")
      end
   endgenerate

endmodule

// ===== rtl/dmst_queue.sv =====
// Two-entry queue between the front end and the table back end.
`include "direct_mapped_slot_stats_table_core_defines.svh"
module dmst_queue
   import dmst_pkg::*;
#(
   parameter int unsigned IDX_W = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  dmst_item_type       push_item,
   input  logic [IDX_W-1:0]    push_idx,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dmst_item_type       pop_item,
   output logic [IDX_W-1:0]    pop_idx
);

   dmst_item_type    item_ff [2];
   logic [IDX_W-1:0] idx_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = item_ff[rd_ptr_ff];
   assign pop_idx    = idx_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push_fire) begin
         item_ff[wr_ptr_ff] <= push_item;
         idx_ff[wr_ptr_ff]  <= push_idx;
      end
   end

   `DMST_ASSERT(a_count_grows, (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 2'd1),
      "queue occupancy did not follow a push")

endmodule

// ===== rtl/dmst_back.sv =====
// Table back end: clearing pass, read-modify-write of entries, result register.
`include "direct_mapped_slot_stats_table_core_defines.svh"
module dmst_back
   import dmst_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned IDX_W         = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 clear_busy,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  dmst_item_type        pop_item,
   input  logic [IDX_W-1:0]     pop_idx,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic [TIME_W-1:0]    rsp_first_time,
   output logic [TIME_W-1:0]    rsp_elapsed,
   output logic [CNT_W-1:0]     rsp_turbine_count,
   output logic [CNT_W-1:0]     rsp_repair_count,
   output logic [CNT_W-1:0]     rsp_recovered_count,
   output logic [CNT_W-1:0]     rsp_coding_count
);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_EXEC  = 2'd2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   dmst_entry_type   mem_ff [TABLE_ENTRIES];
   dmst_entry_type   rd_ff;
   dmst_item_type    cur_ff;
   logic [IDX_W-1:0] cur_idx_ff;
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff;
   logic [TIME_W-1:0] first_ff, elapsed_ff;
   logic [CNT_W-1:0] turbine_ff, repair_ff, recovered_ff, coding_ff;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   dmst_entry_type   mem_wdata;
   logic             pop_fire, hit, out_free, load_rsp;
   dmst_entry_type   base, upd;

   assign clear_busy = (state_ff == B_CLEAR);
   assign pop_ready  = (state_ff == B_IDLE);
   assign pop_fire   = pop_valid && pop_ready;
   assign hit        = (rd_ff.tag == cur_ff.tag);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_rsp   = (state_ff == B_EXEC) && (cur_ff.op == OP_QUERY) && out_free;

   // On a tag miss the entry restarts with the new tag and this beat's time.
   always_comb begin
      if (hit) begin
         base = rd_ff;
      end else begin
         base            = ENTRY_RESET;
         base.tag        = cur_ff.tag;
         base.first_time = cur_ff.ts;
      end
      upd = base;
      case (cur_ff.bump)
         BUMP_TURBINE:   upd.turbine   = base.turbine + 32'd1;
         BUMP_REPAIR:    upd.repair    = base.repair + 32'd1;
         BUMP_RECOVERED: upd.recovered = base.recovered + 32'd1;
         BUMP_CODING:    upd.coding    = base.coding + 32'd1;
         default:        upd           = base;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_idx_ff;
      mem_wdata    = upd;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = ENTRY_RESET;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_fire) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            if (cur_ff.op == OP_CLAIM) begin
               mem_we   = 1'b1;
               state_in = B_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop_fire) begin
         cur_ff     <= pop_item;
         cur_idx_ff <= pop_idx;
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (pop_fire) begin
         rd_ff <= mem_ff[pop_idx];
      end
   end

   // Zero every field of a missed query.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         found_ff     <= hit;
         first_ff     <= hit ? rd_ff.first_time : '0;
         elapsed_ff   <= hit ? (cur_ff.ts - rd_ff.first_time) : '0;
         turbine_ff   <= hit ? rd_ff.turbine : '0;
         repair_ff    <= hit ? rd_ff.repair : '0;
         recovered_ff <= hit ? rd_ff.recovered : '0;
         coding_ff    <= hit ? rd_ff.coding : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = found_ff;
   assign rsp_first_time      = first_ff;
   assign rsp_elapsed         = elapsed_ff;
   assign rsp_turbine_count   = turbine_ff;
   assign rsp_repair_count    = repair_ff;
   assign rsp_recovered_count = recovered_ff;
   assign rsp_coding_count    = coding_ff;

   `DMST_ASSERT(a_no_read_write_clash, !(mem_we && pop_fire),
      "table read and write in the same cycle")
   `DMST_ASSERT(a_query_shows_beat, load_rsp |=> rsp_valid_ff,
      "query finished without a result beat")
   `DMST_ASSERT_ALWAYS(a_clear_blocks_pop, (reset || clear_busy) |=> (!pop_fire || !clear_busy),
      "item taken during the clearing pass")

endmodule

// ===== rtl/direct_mapped_slot_stats_table_core.sv =====
// Direct-mapped slot statistics table: front end, queue and table back end.
//
// After reset the block sweeps the table once, one entry per cycle, and holds
// req_ready low until the sweep is done. Each beat on the request channel
// selects entry slot_number mod TABLE_ENTRIES; start and shred beats claim
// and update it, query beats give one result beat, and kind 3 is taken and
// dropped. The back end takes one item at a time: a registered table read,
// then the update or the result. With a power-of-two TABLE_ENTRIES the front
// end passes each beat straight on to the queue. For other sizes it folds the
// slot number by 16-bit residues and reduces it with a reciprocal multiply
// and a subtract, and it takes no new beat until the last one is queued.
// A two-entry queue and a result register sit between the two sides; a result
// stall holds the back end at a query and, once the queue fills, the input.
`include "direct_mapped_slot_stats_table_core_defines.svh"
module direct_mapped_slot_stats_table_core
   import dmst_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [63:0]               req_slot_number,
   input  logic                      req_is_data,
   input  logic [1:0]                req_source,
   input  logic signed [63:0]        req_timestamp,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic signed [63:0]        rsp_first_time,
   output logic signed [63:0]        rsp_elapsed,
   output logic [31:0]               rsp_turbine_count,
   output logic [31:0]               rsp_repair_count,
   output logic [31:0]               rsp_recovered_count,
   output logic [31:0]               rsp_coding_count
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic             clear_busy;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   dmst_item_type    push_item, pop_item;
   logic [IDX_W-1:0] push_idx, pop_idx;
   logic [63:0]      first_time, elapsed;

   dmst_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_slot_number(req_slot_number),
      .req_is_data    (req_is_data),
      .req_source     (req_source),
      .req_timestamp  (req_timestamp),
      .clear_busy     (clear_busy),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item),
      .push_idx       (push_idx)
   );

   dmst_queue #(
      .IDX_W(IDX_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item (push_item),
      .push_idx  (push_idx),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .pop_idx   (pop_idx)
   );

   dmst_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .clear_busy         (clear_busy),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_item           (pop_item),
      .pop_idx            (pop_idx),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_first_time     (first_time),
      .rsp_elapsed        (elapsed),
      .rsp_turbine_count  (rsp_turbine_count),
      .rsp_repair_count   (rsp_repair_count),
      .rsp_recovered_count(rsp_recovered_count),
      .rsp_coding_count   (rsp_coding_count)
   );

   assign rsp_first_time = signed'(first_time);
   assign rsp_elapsed    = signed'(elapsed);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the direct-mapped slot statistics table core.
module testbench
   import dmst_pkg::*;
();

   localparam int unsigned ENTRIES      = 1024;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [1:0]  SRC_OTHER    = 2'd3;
   localparam int          RAND_ITEMS   = 410;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          HOLD_CYCLES  = 250;
   localparam int          HOLD_AT      = 320;
   localparam int          PAUSE_AT     = 380;
   localparam logic [63:0] TIME_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TIME_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SLOT_ALL1    = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        found;
      logic [63:0] first_time;
      logic [63:0] elapsed;
      logic [31:0] turbine;
      logic [31:0] repair;
      logic [31:0] recovered;
      logic [31:0] coding;
   } slot_record_type;

   class slot_stats_scoreboard;
      logic [63:0]     tags [ENTRIES];
      logic [63:0]     first_seen [ENTRIES];
      logic [31:0]     turbine [ENTRIES];
      logic [31:0]     repair [ENTRIES];
      logic [31:0]     recovered [ENTRIES];
      logic [31:0]     coding [ENTRIES];
      slot_record_type records_due[$];
      int              errors;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            tags[i]       = SLOT_ALL1;
            first_seen[i] = '0;
            turbine[i]    = '0;
            repair[i]     = '0;
            recovered[i]  = '0;
            coding[i]     = '0;
         end
         errors = 0;
      endfunction

      function int unsigned entry_of(logic [63:0] slot);
         return int'(slot % 64'(ENTRIES));
      endfunction

      // Retag the entry and clear its counters when another slot owns it.
      function void claim(int unsigned e, logic [63:0] slot, logic [63:0] ts);
         if (tags[e] != slot) begin
            tags[e]       = slot;
            first_seen[e] = ts;
            turbine[e]    = '0;
            repair[e]     = '0;
            recovered[e]  = '0;
            coding[e]     = '0;
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [63:0] slot, logic is_data,
                                 logic [1:0] source, logic [63:0] ts);
         int unsigned     e;
         slot_record_type rec;
         e = entry_of(slot);
         case (kind)
            KIND_START: claim(e, slot, ts);
            KIND_SHRED: begin
               claim(e, slot, ts);
               if (!is_data) begin
                  coding[e] = coding[e] + 32'd1;
               end else begin
                  case (source)
                     SRC_REPAIR:    repair[e]    = repair[e] + 32'd1;
                     SRC_TURBINE:   turbine[e]   = turbine[e] + 32'd1;
                     SRC_RECOVERED: recovered[e] = recovered[e] + 32'd1;
                     default: ;
                  endcase
               end
            end
            KIND_QUERY: begin
               rec = '0;
               if (tags[e] == slot) begin
                  rec.found      = 1'b1;
                  rec.first_time = first_seen[e];
                  rec.elapsed    = ts - first_seen[e];
                  rec.turbine    = turbine[e];
                  rec.repair     = repair[e];
                  rec.recovered  = recovered[e];
                  rec.coding     = coding[e];
               end
               records_due.push_back(rec);
            end
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return records_due.size();
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(slot_record_type got);
         slot_record_type want;
         if (records_due.size() == 0) begin
            report("result beat with no query outstanding");
            return;
         end
         want = records_due.pop_front();
         if (got.found !== want.found)
            report($sformatf("found got %b want %b", got.found, want.found));
         if (got.first_time !== want.first_time)
            report($sformatf("first_time got %h want %h", got.first_time, want.first_time));
         if (got.elapsed !== want.elapsed)
            report($sformatf("elapsed got %h want %h", got.elapsed, want.elapsed));
         if (got.turbine !== want.turbine)
            report($sformatf("turbine got %h want %h", got.turbine, want.turbine));
         if (got.repair !== want.repair)
            report($sformatf("repair got %h want %h", got.repair, want.repair));
         if (got.recovered !== want.recovered)
            report($sformatf("recovered got %h want %h", got.recovered, want.recovered));
         if (got.coding !== want.coding)
            report($sformatf("coding got %h want %h", got.coding, want.coding));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic [63:0]        req_slot_number;
   logic               req_is_data;
   logic [1:0]         req_source;
   logic signed [63:0] req_timestamp;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_found;
   logic signed [63:0] rsp_first_time;
   logic signed [63:0] rsp_elapsed;
   logic [31:0]        rsp_turbine_count;
   logic [31:0]        rsp_repair_count;
   logic [31:0]        rsp_recovered_count;
   logic [31:0]        rsp_coding_count;

   slot_stats_scoreboard stats_sb = new();
   int                   sent_count = 0;

   direct_mapped_slot_stats_table_core #(
      .TABLE_ENTRIES(ENTRIES)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_slot_number     (req_slot_number),
      .req_is_data         (req_is_data),
      .req_source          (req_source),
      .req_timestamp       (req_timestamp),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_first_time      (rsp_first_time),
      .rsp_elapsed         (rsp_elapsed),
      .rsp_turbine_count   (rsp_turbine_count),
      .rsp_repair_count    (rsp_repair_count),
      .rsp_recovered_count (rsp_recovered_count),
      .rsp_coding_count    (rsp_coding_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // No idling on either side while this window of beats goes through.
   function automatic bit steady_window();
      return (sent_count >= 150) && (sent_count < 260);
   endfunction

   task automatic send_beat(input logic [1:0] kind, input logic [63:0] slot,
                            input logic is_data, input logic [1:0] source,
                            input logic [63:0] ts);
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_slot_number <= slot;
      req_is_data     <= is_data;
      req_source      <= source;
      req_timestamp   <= ts;
      do @(posedge clock); while (!(req_valid && req_ready));
      stats_sb.note_request(kind, slot, is_data, source, ts);
      if (kind != KIND_UNUSED) sent_count++;
      if (!steady_window() && ($urandom_range(0, 99) < 19)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      // Never-claimed entry still carries the all-ones tag.
      send_beat(KIND_QUERY, SLOT_ALL1, 1'b0, SRC_REPAIR, 64'd50);
      send_beat(KIND_QUERY, 64'd0, 1'b0, SRC_REPAIR, 64'd60);
      send_beat(KIND_START, 64'd5, 1'b0, SRC_REPAIR, 64'd100);
      send_beat(KIND_SHRED, 64'd5, 1'b0, SRC_OTHER, 64'd110);
      send_beat(KIND_SHRED, 64'd5, 1'b1, SRC_REPAIR, 64'd120);
      send_beat(KIND_SHRED, 64'd5, 1'b1, SRC_TURBINE, 64'd130);
      send_beat(KIND_SHRED, 64'd5, 1'b1, SRC_RECOVERED, 64'd140);
      send_beat(KIND_SHRED, 64'd5, 1'b1, SRC_OTHER, 64'd150);
      send_beat(KIND_QUERY, 64'd5, 1'b0, SRC_REPAIR, 64'd1000);
      // Same tag again: keep counters and first time.
      send_beat(KIND_START, 64'd5, 1'b0, SRC_REPAIR, 64'd2000);
      send_beat(KIND_QUERY, 64'd5, 1'b1, SRC_OTHER, 64'd2100);
      // Collision on entry 5.
      send_beat(KIND_SHRED, 64'd5 + 64'(ENTRIES), 1'b1, SRC_TURBINE, 64'd3000);
      send_beat(KIND_QUERY, 64'd5, 1'b0, SRC_REPAIR, 64'd3100);
      send_beat(KIND_QUERY, 64'd5 + 64'(ENTRIES), 1'b0, SRC_REPAIR, 64'd3200);
      send_beat(KIND_UNUSED, 64'd5 + 64'(ENTRIES), 1'b1, SRC_TURBINE, 64'd3300);
      send_beat(KIND_QUERY, 64'd5 + 64'(ENTRIES), 1'b0, SRC_REPAIR, 64'd3400);
      // All-ones slot on an unclaimed entry keeps first time zero.
      send_beat(KIND_SHRED, SLOT_ALL1, 1'b1, SRC_TURBINE, TIME_MAX);
      send_beat(KIND_START, SLOT_ALL1, 1'b0, SRC_REPAIR, 64'd77);
      send_beat(KIND_QUERY, SLOT_ALL1, 1'b0, SRC_REPAIR, TIME_MIN);
      // Extreme times: elapsed wraps.
      send_beat(KIND_START, 64'h8000_0000_0000_0007, 1'b0, SRC_REPAIR, TIME_MIN);
      send_beat(KIND_QUERY, 64'h8000_0000_0000_0007, 1'b0, SRC_REPAIR, TIME_MAX);
      send_beat(KIND_UNUSED, {$urandom, $urandom}, 1'b1, SRC_OTHER, {$urandom, $urandom});
      send_beat(KIND_QUERY, 64'd0, 1'b1, SRC_OTHER, 64'd0);
   endtask

   function automatic logic [63:0] make_hot_slot();
      int          r;
      logic [63:0] upper;
      r = $urandom_range(0, 99);
      if (r >= 90) return SLOT_ALL1;
      if (r < 50) upper = 64'($urandom_range(0, 3));
      else upper = {$urandom, $urandom} >> 10;
      return upper * 64'(ENTRIES) + 64'($urandom_range(0, 5));
   endfunction

   task automatic run_random();
      logic [63:0] hot [16];
      logic [63:0] now_ns;
      logic [63:0] slot;
      logic [63:0] ts;
      logic [1:0]  kind;
      int          r;
      int          picks;
      bit          paused;
      for (int i = 0; i < 16; i++) hot[i] = make_hot_slot();
      now_ns = {$urandom, $urandom};
      picks  = 0;
      paused = 1'b0;
      while (picks < RAND_ITEMS) begin
         // Drain all results once mid-run.
         if (!paused && picks == PAUSE_AT) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (stats_sb.pending() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 4) hot[$urandom_range(0, 15)] = make_hot_slot();
         if ($urandom_range(0, 99) < 10) slot = {$urandom, $urandom};
         else slot = hot[$urandom_range(0, 15)];
         r = $urandom_range(0, 99);
         if (r < 12) kind = KIND_START;
         else if (r < 67) kind = KIND_SHRED;
         else if (r < 95) kind = KIND_QUERY;
         else kind = KIND_UNUSED;
         now_ns = now_ns + 64'($urandom_range(1, 5000));
         ts = ($urandom_range(0, 99) < 8) ? {$urandom, $urandom} : now_ns;
         send_beat(kind, slot, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), ts);
         if (kind != KIND_UNUSED) picks++;
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_START;
      req_slot_number = '0;
      req_is_data     = 1'b0;
      req_source      = SRC_REPAIR;
      req_timestamp   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (stats_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (stats_sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Result side: random stalls plus one long hold-off that backs up the input.
   initial begin
      int              hold_left;
      bit              hold_done;
      slot_record_type got;
      rsp_ready = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.found      = rsp_found;
            got.first_time = rsp_first_time;
            got.elapsed    = rsp_elapsed;
            got.turbine    = rsp_turbine_count;
            got.repair     = rsp_repair_count;
            got.recovered  = rsp_recovered_count;
            got.coding     = rsp_coding_count;
            stats_sb.check_response(got);
         end
         if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady_window()) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 19);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench: done, errors");
      $finish;
   end

endmodule
